>>> hw/rtl/ali_pkg.sv
// Shared types, codes and defaults for the array list block.
package ali_pkg;

    localparam int DEF_LIST_DEPTH  = 1024;
    localparam int DEF_ENTRY_WIDTH = 32;

    localparam int MODE_W = 3;
    localparam int POS_W  = 11;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    // request modes
    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_END   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RM_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RM_POS    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RM_END    = 3'd5;

    // response status
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] entry_data;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] removed_data;
        logic [POS_W-1:0]  count_after;
    } rsp_t;

endpackage

>>> hw/rtl/ali_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ali_ram #(
    parameter int WIDTH = ali_pkg::DEF_ENTRY_WIDTH,
    parameter int DEPTH = ali_pkg::DEF_LIST_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    import ali_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/array_list_insert_remove.sv
// Top level: ordered array list with insert/remove at front, position or end.
//
// Ordered list of up to LIST_DEPTH entries held contiguously in one RAM
// (one write port, one registered read port) plus a fill count. Every request
// transaction yields exactly one response transaction carrying a status, the
// removed entry (zero unless a removal succeeded) and the count after the
// request. Errors (full, empty, bad position) and unused modes leave the list
// as it was. Errors, unused modes and inserts at the end finish straight from
// idle; other inserts and removals, with p the target position, do one RAM
// read and one RAM write per cycle while the entries from p (insert) or above
// p (removal) move by one slot. A new request is taken once the previous one
// is done and the response register is free or being drained. The RAM needs
// no clearing pass: only entries below the count are ever read.
module array_list_insert_remove #(
    parameter int LIST_DEPTH  = ali_pkg::DEF_LIST_DEPTH,
    parameter int ENTRY_WIDTH = ali_pkg::DEF_ENTRY_WIDTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ali_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ali_pkg::rsp_t rsp
);
    import ali_pkg::*;

    localparam int AW = $clog2(LIST_DEPTH);       // RAM address
    localparam int CW = $clog2(LIST_DEPTH + 1);   // fill count, holds LIST_DEPTH
    localparam int PW = (CW > POS_W) ? CW : POS_W; // position compare width

    typedef enum logic [2:0] {
        IDLE,
        SHIFT_UP,   // insert: move entries up, top down to target
        PUT,        // insert: write new entry into the gap
        RM_HEAD,    // remove: capture the removed entry
        SHIFT_DN    // remove: move entries down, target up to top
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;       // address whose data is on rdata
    logic [AW-1:0]    pos_reg, pos_next;       // insert target
    logic [AW-1:0]    last_reg, last_next;     // top entry for removal
    logic [ENTRY_WIDTH-1:0] data_reg, data_next;
    logic [ENTRY_WIDTH-1:0] removed_reg, removed_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    // RAM port
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENTRY_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    // request decode
    logic                   accept;
    logic                   is_ins, is_rm, full, empty;
    logic [PW-1:0]          cnt_w, pos_in, ins_pos, rm_pos;
    logic [ENTRY_WIDTH-1:0] din;

    // completion
    logic                   fin;
    logic [ST_W-1:0]        fin_status;
    logic [ENTRY_WIDTH-1:0] fin_removed;
    logic [CW-1:0]          fin_count;

    ali_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one transaction at a time; the response register parts the two sides
    assign req_stall = (state_reg != IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign is_ins = (req.mode == MODE_INS_FRONT) || (req.mode == MODE_INS_POS) ||
                    (req.mode == MODE_INS_END);
    assign is_rm  = (req.mode == MODE_RM_FRONT) || (req.mode == MODE_RM_POS) ||
                    (req.mode == MODE_RM_END);
    assign full   = (count_reg == CW'(LIST_DEPTH));
    assign empty  = (count_reg == '0);
    assign cnt_w  = PW'(count_reg);
    assign pos_in = PW'(req.position);
    assign din    = ENTRY_WIDTH'(req.entry_data);

    always_comb
    begin
        case (req.mode)
            MODE_INS_FRONT: ins_pos = '0;
            MODE_INS_POS:   ins_pos = pos_in;
            default:        ins_pos = cnt_w;
        endcase
        case (req.mode)
            MODE_RM_FRONT: rm_pos = '0;
            MODE_RM_POS:   rm_pos = pos_in;
            default:       rm_pos = cnt_w - 1'b1;  // empty case caught first
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        data_next    = data_reg;
        removed_next = removed_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = data_reg;
        ram_raddr = idx_reg;

        fin         = 1'b0;
        fin_status  = ST_DONE;
        fin_removed = '0;
        fin_count   = count_reg;

        case (state_reg)
            IDLE:
            begin
                if (accept)
                begin
                    if (is_ins)
                    begin
                        if (full)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                        end
                        else if (ins_pos > cnt_w)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_RANGE;
                        end
                        else if (ins_pos == cnt_w)
                        begin
                            // append: nothing to move
                            ram_we     = 1'b1;
                            ram_waddr  = AW'(ins_pos);
                            ram_wdata  = din;
                            count_next = count_reg + 1'b1;
                            fin        = 1'b1;
                            fin_count  = count_reg + 1'b1;
                        end
                        else
                        begin
                            ram_raddr  = AW'(count_reg - 1'b1);
                            idx_next   = AW'(count_reg - 1'b1);
                            pos_next   = AW'(ins_pos);
                            data_next  = din;
                            state_next = SHIFT_UP;
                        end
                    end
                    else if (is_rm)
                    begin
                        if (empty)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end
                        else if (rm_pos >= cnt_w)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_RANGE;
                        end
                        else
                        begin
                            ram_raddr  = AW'(rm_pos);
                            idx_next   = AW'(rm_pos);
                            last_next  = AW'(count_reg - 1'b1);
                            state_next = RM_HEAD;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;   // unused mode: no-op
                    end
                end
            end

            SHIFT_UP:
            begin
                // write slot idx+1 while reading idx-1: never the same entry
                ram_we    = 1'b1;
                ram_waddr = idx_reg + 1'b1;
                ram_wdata = ram_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = PUT;
                end
                else
                begin
                    ram_raddr = idx_reg - 1'b1;
                    idx_next  = idx_reg - 1'b1;
                end
            end

            PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = data_reg;
                count_next = count_reg + 1'b1;
                fin        = 1'b1;
                fin_count  = count_reg + 1'b1;
                state_next = IDLE;
            end

            RM_HEAD:
            begin
                removed_next = ram_rdata;
                if (idx_reg == last_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    fin         = 1'b1;
                    fin_removed = ram_rdata;
                    fin_count   = count_reg - 1'b1;
                    state_next  = IDLE;
                end
                else
                begin
                    ram_raddr  = idx_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = SHIFT_DN;
                end
            end

            SHIFT_DN:
            begin
                // write slot idx-1 while reading idx+1
                ram_we    = 1'b1;
                ram_waddr = idx_reg - 1'b1;
                ram_wdata = ram_rdata;
                if (idx_reg == last_reg)
                begin
                    count_next  = count_reg - 1'b1;
                    fin         = 1'b1;
                    fin_removed = removed_reg;
                    fin_count   = count_reg - 1'b1;
                    state_next  = IDLE;
                end
                else
                begin
                    ram_raddr = idx_reg + 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase

        // response register: drains on !rsp_stall, loads on completion
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        if (fin)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = fin_status;
            rsp_next.removed_data = DATA_W'(fin_removed);
            rsp_next.count_after  = POS_W'(fin_count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            last_reg      <= '0;
            data_reg      <= '0;
            removed_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            last_reg      <= last_next;
            data_reg      <= data_next;
            removed_reg   <= removed_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // fill count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LIST_DEPTH))
        else $error("fill count above list depth");

    // writes stay inside the list or the one slot above it
    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) <= count_reg))
        else $error("RAM write outside the list");

    // while moving entries, read and write never hit the same slot
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == SHIFT_UP) || (state_reg == SHIFT_DN)) |-> (ram_waddr != ram_raddr))
        else $error("RAM read/write overlap during shift");

    // an accepted request is either in progress or answered next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg != IDLE) || rsp_valid_reg))
        else $error("accepted request neither busy nor answered");

    // a response appears only once the sequencer is back at rest
    a_rsp_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> (state_reg == IDLE))
        else $error("response raised while still shifting");

endmodule
